[design/mts_pkg.sv]
// Shared constants for the midpoint triangle subdivider.
`timescale 1ns / 1ps
`default_nettype none

package mts_pkg;

  // Default build sizes.
  localparam int MAX_LEVELS_DEF = 3;
  localparam int COORD_BITS_DEF = 24;

  // Configuration port layout.
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;
  localparam logic [0:0] REG_LEVELS = 1'b0;
  localparam logic [1:0] LEVELS_RESET = 2'd1;

  // Child codes of one split, in emission order.
  localparam logic [1:0] CHILD_A      = 2'd0;
  localparam logic [1:0] CHILD_B      = 2'd1;
  localparam logic [1:0] CHILD_C      = 2'd2;
  localparam logic [1:0] CHILD_CENTER = 2'd3;

endpackage

`default_nettype wire

[design/mts_in_if.sv]
// Input channel carrying one triangle item.
`timescale 1ns / 1ps
`default_nettype none

interface mts_in_if #(
  parameter int COORD_BITS = mts_pkg::COORD_BITS_DEF
) ();
  import mts_pkg::*;

  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] a_x;
  logic signed [COORD_BITS-1:0] a_y;
  logic signed [COORD_BITS-1:0] a_z;
  logic signed [COORD_BITS-1:0] b_x;
  logic signed [COORD_BITS-1:0] b_y;
  logic signed [COORD_BITS-1:0] b_z;
  logic signed [COORD_BITS-1:0] c_x;
  logic signed [COORD_BITS-1:0] c_y;
  logic signed [COORD_BITS-1:0] c_z;

  modport source (
    output valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
    input  ready
  );
  modport sink (
    input  valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
    output ready
  );
endinterface

`default_nettype wire

[design/mts_out_if.sv]
// Output channel carrying one result triangle item.
`timescale 1ns / 1ps
`default_nettype none

interface mts_out_if #(
  parameter int COORD_BITS = mts_pkg::COORD_BITS_DEF
) ();
  import mts_pkg::*;

  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] out_a_x;
  logic signed [COORD_BITS-1:0] out_a_y;
  logic signed [COORD_BITS-1:0] out_a_z;
  logic signed [COORD_BITS-1:0] out_b_x;
  logic signed [COORD_BITS-1:0] out_b_y;
  logic signed [COORD_BITS-1:0] out_b_z;
  logic signed [COORD_BITS-1:0] out_c_x;
  logic signed [COORD_BITS-1:0] out_c_y;
  logic signed [COORD_BITS-1:0] out_c_z;
  logic                         last_piece;

  modport source (
    output valid, out_a_x, out_a_y, out_a_z, out_b_x, out_b_y, out_b_z,
           out_c_x, out_c_y, out_c_z, last_piece,
    input  ready
  );
  modport sink (
    input  valid, out_a_x, out_a_y, out_a_z, out_b_x, out_b_y, out_b_z,
           out_c_x, out_c_y, out_c_z, last_piece,
    output ready
  );
endinterface

`default_nettype wire

[design/midpoint_triangle_subdivider_top.sv]
// Midpoint triangle subdivider: one input triangle in, 4^levels sub-triangles out.
//
// Each accepted triangle is split by edge midpoints to the depth held in the
// levels register (saturated to MAX_LEVELS) and the children are sent out
// depth-first, the final one flagged by last_piece. A single midpoint unit forms
// one child triangle per cycle from a small per-level stack while descending;
// each emit waits while the output register is full and not being taken. The
// input is not ready while an item is being worked on; the last result may still
// wait in the output register while the next item is taken.
`timescale 1ns / 1ps
`default_nettype none

module midpoint_triangle_subdivider_top #(
  parameter int MAX_LEVELS = mts_pkg::MAX_LEVELS_DEF,
  parameter int COORD_BITS = mts_pkg::COORD_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  mts_in_if.sink                               tri_in,
  mts_out_if.source                            tri_out,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [mts_pkg::APB_ADDR_W-1:0]  paddr,
  input  wire logic [mts_pkg::APB_DATA_W-1:0]  pwdata,
  output logic      [mts_pkg::APB_DATA_W-1:0]  prdata,
  output logic                                 pready
);
  import mts_pkg::*;

  localparam int LVL_W = $clog2(MAX_LEVELS + 1);
  localparam logic [1:0] MAX_LV2 = 2'(MAX_LEVELS);

  typedef logic [2:0][COORD_BITS-1:0] vtx_t;
  typedef vtx_t [2:0] trig_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DESC = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

  // Floor of the mean of two coordinates, formed one bit wider.
  function automatic logic [COORD_BITS-1:0] mid_coord(input logic [COORD_BITS-1:0] s,
                                                      input logic [COORD_BITS-1:0] t);
    logic [COORD_BITS:0] sum;
    sum = {s[COORD_BITS-1], s} + {t[COORD_BITS-1], t};
    return sum[COORD_BITS:1];
  endfunction

  function automatic vtx_t mid_vtx(input vtx_t p, input vtx_t q);
    vtx_t m;
    for (int k = 0; k < 3; k++) begin
      m[k] = mid_coord(p[k], q[k]);
    end
    return m;
  endfunction

  state_t           state;
  logic [1:0]       levels;
  logic [LVL_W-1:0] depth;
  logic [LVL_W-1:0] lvl;
  logic [1:0]       dig [MAX_LEVELS+1];
  trig_t            stack [MAX_LEVELS+1];
  trig_t            out_tri;
  logic             out_valid;
  logic             out_last;

  trig_t            cur;
  trig_t            child;
  vtx_t             m_pq;
  vtx_t             m_qr;
  vtx_t             m_rp;
  logic             found;
  logic [LVL_W-1:0] nxt_lvl;
  logic             is_last;
  logic             out_free;
  logic             cfg_wr;
  logic [1:0]       lv_sat;

  // Configuration register.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[APB_ADDR_W-1:2] == REG_LEVELS);

  always_comb begin
    prdata = '0;
    if (paddr[APB_ADDR_W-1:2] == REG_LEVELS) begin
      prdata[1:0] = levels;
    end
  end

  assign lv_sat = (levels > MAX_LV2) ? MAX_LV2 : levels;

  // Shared midpoint unit: one child of the current level per cycle.
  always_comb begin
    cur  = stack[lvl];
    m_pq = mid_vtx(cur[0], cur[1]);
    m_qr = mid_vtx(cur[1], cur[2]);
    m_rp = mid_vtx(cur[2], cur[0]);
    unique case (dig[lvl])
      CHILD_A:      child = '{m_rp, m_pq, cur[0]};
      CHILD_B:      child = '{m_pq, m_qr, cur[1]};
      CHILD_C:      child = '{m_qr, m_rp, cur[2]};
      CHILD_CENTER: child = '{m_rp, m_qr, m_pq};
    endcase
  end

  // Deepest level whose child index can still advance; none means last piece.
  always_comb begin
    found   = 1'b0;
    nxt_lvl = '0;
    for (int k = 0; k < MAX_LEVELS; k++) begin
      if ((LVL_W'(k) < depth) && (dig[k] != CHILD_CENTER)) begin
        found   = 1'b1;
        nxt_lvl = LVL_W'(k);
      end
    end
    is_last = !found;
  end

  assign out_free = !out_valid || tri_out.ready;

  // Sequencer and control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      levels    <= LEVELS_RESET;
      out_valid <= 1'b0;
      lvl       <= '0;
      depth     <= '0;
      for (int k = 0; k <= MAX_LEVELS; k++) begin
        dig[k] <= CHILD_A;
      end
    end else begin
      if (cfg_wr) begin
        levels <= pwdata[1:0];
      end
      // The output register fills on an emit and empties when taken.
      if ((state == ST_EMIT) && out_free) begin
        out_valid <= 1'b1;
      end else if (tri_out.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (tri_in.valid) begin
            depth <= LVL_W'(lv_sat);
            lvl   <= '0;
            for (int k = 0; k <= MAX_LEVELS; k++) begin
              dig[k] <= CHILD_A;
            end
            state <= (lv_sat == 2'd0) ? ST_EMIT : ST_DESC;
          end
        end
        ST_DESC: begin
          lvl <= lvl + 1'b1;
          if (lvl + 1'b1 == depth) begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            if (is_last) begin
              state <= ST_IDLE;
            end else begin
              dig[nxt_lvl] <= dig[nxt_lvl] + 2'd1;
              for (int k = 0; k <= MAX_LEVELS; k++) begin
                if (LVL_W'(k) > nxt_lvl) begin
                  dig[k] <= CHILD_A;
                end
              end
              lvl   <= nxt_lvl;
              state <= ST_DESC;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Triangle stack and output register.
  always_ff @(posedge clk) begin
    if ((state == ST_IDLE) && tri_in.valid) begin
      stack[0] <= '{'{tri_in.c_z, tri_in.c_y, tri_in.c_x},
                    '{tri_in.b_z, tri_in.b_y, tri_in.b_x},
                    '{tri_in.a_z, tri_in.a_y, tri_in.a_x}};
    end
    if (state == ST_DESC) begin
      stack[lvl + 1'b1] <= child;
    end
    if ((state == ST_EMIT) && out_free) begin
      out_tri  <= stack[lvl];
      out_last <= is_last;
    end
  end

  // Channel outputs.
  assign tri_in.ready       = (state == ST_IDLE);
  assign tri_out.valid      = out_valid;
  assign tri_out.out_a_x    = out_tri[0][0];
  assign tri_out.out_a_y    = out_tri[0][1];
  assign tri_out.out_a_z    = out_tri[0][2];
  assign tri_out.out_b_x    = out_tri[1][0];
  assign tri_out.out_b_y    = out_tri[1][1];
  assign tri_out.out_b_z    = out_tri[1][2];
  assign tri_out.out_c_x    = out_tri[2][0];
  assign tri_out.out_c_y    = out_tri[2][1];
  assign tri_out.out_c_z    = out_tri[2][2];
  assign tri_out.last_piece = out_last;

endmodule

`default_nettype wire

[design/mts_checker.sv]
// Port-level assertions for the midpoint triangle subdivider, with their bind.
`timescale 1ns / 1ps
`default_nettype none

module mts_checker #(
  parameter int COORD_BITS = mts_pkg::COORD_BITS_DEF
) (
  input wire logic                    clk,
  input wire logic                    rst,
  input wire logic                    in_valid,
  input wire logic                    in_ready,
  input wire logic                    out_valid,
  input wire logic                    out_ready,
  input wire logic                    out_last,
  input wire logic [9*COORD_BITS-1:0] out_data
);
  import mts_pkg::*;

  // A stalled result item holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data) && $stable(out_last))
    else $error("result item changed while stalled");

  // Once an item is taken, the block is busy in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready right after an accepted item");

  // A result that is not the final piece is only delivered while still busy.
  a_not_last_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !out_last |-> !in_ready)
    else $error("non-final result delivered while idle");

  // Only the final piece may wait at the output while the block is idle.
  a_idle_only_last: assert property (@(posedge clk) disable iff (rst)
    in_ready && out_valid |-> out_last)
    else $error("non-final result pending while idle");

endmodule

bind midpoint_triangle_subdivider_top mts_checker #(.COORD_BITS(COORD_BITS)) u_mts_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (tri_in.valid),
  .in_ready  (tri_in.ready),
  .out_valid (tri_out.valid),
  .out_ready (tri_out.ready),
  .out_last  (tri_out.last_piece),
  .out_data  ({tri_out.out_a_x, tri_out.out_a_y, tri_out.out_a_z,
               tri_out.out_b_x, tri_out.out_b_y, tri_out.out_b_z,
               tri_out.out_c_x, tri_out.out_c_y, tri_out.out_c_z})
);

`default_nettype wire

[tb/tb.sv]
// Self-checking testbench for the midpoint triangle subdivider top level.
`timescale 1ns / 1ps

module tb;
  import mts_pkg::*;

  localparam int CW = COORD_BITS_DEF;
  localparam logic [APB_ADDR_W-1:0] LEVELS_ADDR = APB_ADDR_W'(4 * REG_LEVELS);
  // Byte address of register index one, which the block does not implement.
  localparam logic [APB_ADDR_W-1:0] UNUSED_ADDR = APB_ADDR_W'(4);

  typedef logic [CW-1:0] coord_t;
  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } vert_t;
  typedef struct packed {
    vert_t a;
    vert_t b;
    vert_t c;
  } tri_t;
  typedef struct packed {
    tri_t t;
    logic last;
  } piece_t;

  localparam coord_t COORD_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam coord_t COORD_MIN = {1'b1, {(CW-1){1'b0}}};

  logic clk = 1'b0;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic pready;

  mts_in_if  #(.COORD_BITS(CW)) in_ch ();
  mts_out_if #(.COORD_BITS(CW)) out_ch ();

  midpoint_triangle_subdivider_top #(
    .MAX_LEVELS(MAX_LEVELS_DEF),
    .COORD_BITS(CW)
  ) dut (
    .clk    (clk),
    .rst    (rst),
    .tri_in (in_ch),
    .tri_out(out_ch),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  // Shadow of the depth register and the pieces still owed by the block.
  logic [1:0] shadow_levels = LEVELS_RESET;
  piece_t     pending_pieces[$];
  int         errors = 0;
  int         tris_sent = 0;
  int         pieces_seen = 0;
  int         src_idle_pct = 0;
  int         sink_stall_pct = 0;

  always #6 clk = ~clk;

  // Midpoint of two coordinates: one-bit-wider sum, then floor by one shift.
  function automatic coord_t half_sum(coord_t p, coord_t q);
    logic [CW:0] s;
    s = {p[CW-1], p} + {q[CW-1], q};
    return s[CW:1];
  endfunction

  function automatic vert_t mid_vert(vert_t p, vert_t q);
    vert_t m;
    m.x = half_sum(p.x, q.x);
    m.y = half_sum(p.y, q.y);
    m.z = half_sum(p.z, q.z);
    return m;
  endfunction

  // One of the four children of a split, selected by its child code.
  function automatic tri_t child_tri(tri_t t, logic [1:0] which);
    vert_t pq;
    vert_t qr;
    vert_t rp;
    tri_t  r;
    pq = mid_vert(t.a, t.b);
    qr = mid_vert(t.b, t.c);
    rp = mid_vert(t.c, t.a);
    // The center child unless a corner code is given.
    r = '{pq, qr, rp};
    case (which)
      CHILD_A: r = '{t.a, pq, rp};
      CHILD_B: r = '{t.b, qr, pq};
      CHILD_C: r = '{t.c, rp, qr};
      default: ;
    endcase
    return r;
  endfunction

  // Depth-first pieces of one triangle: the base-4 digits of the piece index,
  // most significant first, give the child taken at each level.
  function automatic void predict_pieces(tri_t t);
    int     depth;
    int     n;
    tri_t   cur;
    piece_t p;
    depth = (int'(shadow_levels) > MAX_LEVELS_DEF) ? MAX_LEVELS_DEF : int'(shadow_levels);
    n = 1 << (2 * depth);
    for (int i = 0; i < n; i++) begin
      cur = t;
      for (int l = depth - 1; l >= 0; l--) begin
        cur = child_tri(cur, 2'((i >> (2 * l)) & 3));
      end
      p.t = cur;
      p.last = (i == n - 1);
      pending_pieces = {pending_pieces, p};
    end
  endfunction

  function automatic vert_t mk_vert(int x, int y, int z);
    vert_t v;
    v.x = coord_t'(x);
    v.y = coord_t'(y);
    v.z = coord_t'(z);
    return v;
  endfunction

  function automatic coord_t rand_coord();
    case ($urandom_range(0, 9))
      0: return COORD_MAX;
      1: return COORD_MIN;
      2: return coord_t'(int'($urandom_range(0, 512)) - 256);
      default: return coord_t'($urandom());
    endcase
  endfunction

  function automatic tri_t rand_tri();
    tri_t t;
    t.a = '{rand_coord(), rand_coord(), rand_coord()};
    t.b = '{rand_coord(), rand_coord(), rand_coord()};
    t.c = '{rand_coord(), rand_coord(), rand_coord()};
    // Now and then a degenerate triangle with two equal vertices.
    if ($urandom_range(0, 9) == 0) t.b = t.a;
    return t;
  endfunction

  // Offer one triangle after a random gap and hold it until it is taken.
  task automatic send_tri(tri_t t);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.a_x <= t.a.x;
    in_ch.a_y <= t.a.y;
    in_ch.a_z <= t.a.z;
    in_ch.b_x <= t.b.x;
    in_ch.b_y <= t.b.y;
    in_ch.b_z <= t.b.z;
    in_ch.c_x <= t.c.x;
    in_ch.c_y <= t.c.y;
    in_ch.c_z <= t.c.z;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_pieces(t);
    tris_sent++;
  endtask

  // Drop valid and wait for the block to drain before touching its register.
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending_pieces.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Two-phase register write; the shadow follows at the access edge.
  task automatic reg_write(logic [APB_ADDR_W-1:0] addr, logic [APB_DATA_W-1:0] data);
    drain();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if ((int'(addr) >> 2) == int'(REG_LEVELS)) shadow_levels = data[1:0];
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic check_field(string what, coord_t want, coord_t got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d",
               $time, what, $signed(want), $signed(got));
      errors++;
    end
  endtask

  // Result sink: random stalls on ready.
  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
  end

  // Compare each accepted piece with the oldest one owed.
  always @(posedge clk) begin
    piece_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      pieces_seen++;
      if (pending_pieces.size() == 0) begin
        $display("%0t: unexpected piece, expected none, actual a_x %0d last_piece %0b",
                 $time, $signed(out_ch.out_a_x), out_ch.last_piece);
        errors++;
      end else begin
        want = pending_pieces.pop_front();
        check_field("out_a_x", want.t.a.x, out_ch.out_a_x);
        check_field("out_a_y", want.t.a.y, out_ch.out_a_y);
        check_field("out_a_z", want.t.a.z, out_ch.out_a_z);
        check_field("out_b_x", want.t.b.x, out_ch.out_b_x);
        check_field("out_b_y", want.t.b.y, out_ch.out_b_y);
        check_field("out_b_z", want.t.b.z, out_ch.out_b_z);
        check_field("out_c_x", want.t.c.x, out_ch.out_c_x);
        check_field("out_c_y", want.t.c.y, out_ch.out_c_y);
        check_field("out_c_z", want.t.c.z, out_ch.out_c_z);
        check_field("last_piece", coord_t'(want.last), coord_t'(out_ch.last_piece));
      end
    end
  end

  // Depth one straight out of reset.
  task automatic test_reset_levels();
    send_tri('{mk_vert(0, 0, 0), mk_vert(0, 0, 0), mk_vert(0, 0, 0)});
    send_tri('{mk_vert(65536, 0, 0), mk_vert(0, 65536, 0), mk_vert(0, 0, 65536)});
  endtask

  // Full-scale coordinates and alternating bit patterns.
  task automatic test_coordinate_extremes();
    send_tri('{'{COORD_MAX, COORD_MAX, COORD_MAX}, '{COORD_MAX, COORD_MAX, COORD_MAX},
               '{COORD_MAX, COORD_MAX, COORD_MAX}});
    send_tri('{'{COORD_MIN, COORD_MIN, COORD_MIN}, '{COORD_MIN, COORD_MIN, COORD_MIN},
               '{COORD_MIN, COORD_MIN, COORD_MIN}});
    send_tri('{'{COORD_MAX, COORD_MIN, COORD_MAX}, '{COORD_MIN, COORD_MAX, COORD_MIN},
               '{COORD_MAX, COORD_MAX, COORD_MIN}});
    send_tri('{mk_vert('hAAAAAA, 'h555555, 'hAAAAAA), mk_vert('h555555, 'hAAAAAA, 'h555555),
               mk_vert('hAAAAAA, 'hAAAAAA, 'h555555)});
  endtask

  // Odd sums, negative ones included, must round toward minus infinity.
  task automatic test_midpoint_rounding();
    send_tri('{mk_vert(-1, -3, 1), mk_vert(-2, 0, 2), mk_vert(0, -1, -5)});
  endtask

  // Depth zero passes the triangle through; stray bits and addresses do nothing.
  task automatic test_pass_through();
    reg_write(LEVELS_ADDR, 32'hFFFF_FFFC);
    send_tri('{mk_vert(1, 2, 3), mk_vert(-4, -5, -6), mk_vert(7, -8, 9)});
    send_tri('{'{COORD_MIN, COORD_MAX, COORD_MIN}, mk_vert(0, 0, 0),
               '{COORD_MAX, COORD_MIN, COORD_MAX}});
    reg_write(UNUSED_ADDR, 32'h0000_0003);
    send_tri('{mk_vert(-100, 200, -300), mk_vert(5, 5, 5), mk_vert(-7, 11, 13)});
  endtask

  // Depths two and three with full-scale and random triangles.
  task automatic test_deep_split();
    reg_write(LEVELS_ADDR, 32'h0000_0002);
    send_tri('{'{COORD_MAX, COORD_MIN, COORD_MAX}, '{COORD_MIN, COORD_MAX, COORD_MIN},
               mk_vert(-1, 1, -1)});
    send_tri(rand_tri());
    reg_write(LEVELS_ADDR, 32'h0000_0003);
    send_tri('{'{COORD_MIN, COORD_MIN, COORD_MAX}, '{COORD_MAX, COORD_MAX, COORD_MIN},
               mk_vert(3, -3, 0)});
    send_tri(rand_tri());
  endtask

  // Random triangles at every depth under one flow-control mix.
  task automatic test_random_mix(int src_pct, int sink_pct);
    int count_at[4];
    count_at = '{10, 12, 12, 6};
    src_idle_pct = src_pct;
    sink_stall_pct = sink_pct;
    for (int d = 0; d < 4; d++) begin
      reg_write(LEVELS_ADDR, {30'($urandom() >> 2), 2'(d)});
      for (int i = 0; i < count_at[d]; i++) send_tri(rand_tri());
    end
  endtask

  initial begin
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_ch.valid = 1'b0;
    in_ch.a_x = '0;
    in_ch.a_y = '0;
    in_ch.a_z = '0;
    in_ch.b_x = '0;
    in_ch.b_y = '0;
    in_ch.b_z = '0;
    in_ch.c_x = '0;
    in_ch.c_y = '0;
    in_ch.c_z = '0;
    out_ch.ready = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_levels();
    test_coordinate_extremes();
    test_midpoint_rounding();
    test_pass_through();
    test_deep_split();
    test_random_mix(0, 0);
    test_random_mix(86, 0);
    test_random_mix(0, 86);
    test_random_mix(38, 38);

    // Let everything drain, then watch a while longer for stray pieces.
    drain();
    repeat (160) @(posedge clk);

    $display("Sent %0d triangles and checked %0d pieces at depths zero through three,",
             tris_sent, pieces_seen);
    $display("under free flow, idle input, stalled output and both at once.");
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog far beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("%0t: timeout with %0d pieces still owed", $time, pending_pieces.size());
    $display("Test completed with failures");
    $finish;
  end

endmodule

[sim.f]
design/mts_pkg.sv
design/mts_in_if.sv
design/mts_out_if.sv
design/midpoint_triangle_subdivider_top.sv
design/mts_checker.sv
tb/tb.sv
